[rtl/pas_pkg.sv]
package pas_pkg;

  localparam int PosW   = 20;
  localparam int VelW   = 18;
  localparam int PixW   = 12;
  localparam int DiffW  = 22;
  localparam int MagW   = 21;
  localparam int SqW    = 42;
  localparam int RootW  = 21;
  localparam int QuotW  = 8;
  localparam int NumW   = 37;
  localparam int DenW   = 29;

  localparam int unsigned BorderPxDefault = 100;

  localparam logic [15:0] ForceQ16 = 16'd19661;
  localparam logic [15:0] DampQ16  = 16'd63242;

  localparam logic signed [VelW-1:0] VelMax = 18'sd131071;
  localparam logic signed [VelW-1:0] VelMin = -18'sd131072;

  localparam logic [1:0] RegFieldWidth  = 2'd0;
  localparam logic [1:0] RegFieldHeight = 2'd1;
  localparam logic [1:0] RegDragFactor  = 2'd2;

  // Product by a Q0.16 factor, rounded to nearest with the half going up.
  function automatic logic [VelW-1:0] round_q16(input logic [SqW-1:0] p);
    logic [SqW-1:0] s;
    s = p + SqW'(32768);
    return s[16 +: VelW];
  endfunction

endpackage

[rtl/particle_attractor_step_unit.sv]
// Channel   Direction  Word
// s_axis    in         tdata: now_ms, target_x, target_y, next_period_ms
// m_axis    out        tdata: pos_x, pos_y; tuser: retargeted, vel_saturated
// cfg       in         write enable, register index, write data
//
// One frame word passes from S_PREP to S_MOVE once it is accepted, and when the particle lies in the
// border its velocity is damped in S_DAMPX, S_DAMPY and S_DAMPF before the move. The
// bit-serial square root holds the sequence, and so does each of the two bit-serial
// divides for the force; when the particle sits on its target both divides are
// skipped. The multiplies are done one per state.
// Reset is synchronous and returns every piece of particle state to zero, so
// the first word always retargets. A stalled result holds in the output
// register; the next word is accepted once the previous one has been computed.
module particle_attractor_step_unit #(
  parameter int unsigned BORDER_PX = pas_pkg::BorderPxDefault
) (
  input  logic        clk,
  input  logic        rst,
  // now_ms[31:0], target_x[43:32], target_y[55:44], next_period_ms[71:56]
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[19:0], pos_y[39:20]
  output logic [39:0] m_axis_tdata,
  // retargeted[0], vel_saturated[1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_SQX, S_SQY, S_SUM, S_ROOT, S_DRAGX, S_DRAGY, S_FXM,
    S_DIVX, S_FYM, S_DIVY, S_SAT, S_DAMPX, S_DAMPY, S_DAMPF, S_MOVE
  } state_t;

  localparam logic signed [DiffW-1:0] BorderLo = DiffW'(BORDER_PX * 256);

  state_t state;

  logic [PixW-1:0] field_width;
  logic [PixW-1:0] field_height;
  logic [15:0]     drag_factor;

  logic [PosW-1:0]        position_x, position_y;
  logic signed [VelW-1:0] velocity_x, velocity_y;
  logic [PixW-1:0]        attract_x, attract_y;
  logic [31:0]            period_start_ms;
  logic [15:0]            period_length_ms;

  logic            retg, clip, border;
  logic [MagW-1:0] adx, ady;
  logic            ndx, ndy;
  logic [SqW-1:0]  prod, sumsq;
  logic [RootW-1:0] len;
  logic signed [VelW:0] vdx, vdy;
  logic [QuotW-1:0] fx, fy;

  logic            accept;
  logic [31:0]     now;
  logic            sq_start, sq_done;
  logic [RootW-1:0] sq_root;
  logic            dv_start, dv_done;
  logic [QuotW-1:0] dv_quot;
  logic [NumW-1:0] dv_num;
  logic [DenW-1:0] dv_den;

  logic signed [DiffW-1:0] dx_s, dy_s, hix, hiy, pxs, pys;
  logic signed [VelW+1:0]  sx, sy;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign now           = s_axis_tdata[31:0];

  assign dx_s = DiffW'({attract_x, 8'b0}) - DiffW'(position_x);
  assign dy_s = DiffW'({attract_y, 8'b0}) - DiffW'(position_y);
  assign hix  = DiffW'({field_width, 8'b0}) - BorderLo;
  assign hiy  = DiffW'({field_height, 8'b0}) - BorderLo;
  assign pxs  = DiffW'(position_x);
  assign pys  = DiffW'(position_y);

  assign dv_den = {len, 8'b0};
  assign dv_num = prod[NumW-1:0] + NumW'({len, 7'b0});

  // Force added to the dragged velocity, with the sign of the distance.
  assign sx = (VelW+2)'(vdx) + (ndx ? -(VelW+2)'(fx) : (VelW+2)'(fx));
  assign sy = (VelW+2)'(vdy) + (ndy ? -(VelW+2)'(fy) : (VelW+2)'(fy));

  pas_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sumsq + prod),
    .done  (sq_done),
    .root  (sq_root)
  );

  pas_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  function automatic logic [MagW-1:0] mag_of(input logic signed [VelW-1:0] v);
    return v[VelW-1] ? MagW'(-(MagW'(signed'(v)))) : MagW'(v);
  endfunction

  function automatic logic signed [VelW:0] apply_sign(input logic neg,
                                                      input logic [VelW-1:0] m);
    return neg ? -(VelW+1)'(m) : (VelW+1)'(m);
  endfunction

  function automatic logic signed [VelW-1:0] sat20(input logic signed [VelW+1:0] v);
    if (v > (VelW+2)'(VelMax)) return VelMax;
    if (v < (VelW+2)'(VelMin)) return VelMin;
    return v[VelW-1:0];
  endfunction

  // One axis of the Euler move with bounce at zero and at the field edge.
  typedef struct packed {
    logic [PosW-1:0]        pos;
    logic signed [VelW-1:0] vel;
    logic                   clip;
  } axis_t;

  function automatic axis_t move_axis(input logic [PosW-1:0] pos,
                                      input logic signed [VelW-1:0] vel,
                                      input logic [PixW-1:0] lim_px);
    axis_t r;
    logic [MagW-1:0] m;
    logic [MagW-1:0] step;
    logic signed [DiffW-1:0] np;
    logic signed [DiffW-1:0] lim;
    m    = mag_of(vel);
    step = (m + MagW'(4)) >> 3;
    np   = vel[VelW-1] ? DiffW'(pos) - DiffW'(step) : DiffW'(pos) + DiffW'(step);
    lim  = DiffW'({lim_px, 8'b0});
    r.clip = 1'b0;
    r.vel  = vel;
    r.pos  = np[PosW-1:0];
    if (np > lim || np < 0) begin
      r.pos = (np > lim) ? lim[PosW-1:0] : '0;
      if (vel == VelMin) begin
        r.vel  = VelMax;
        r.clip = 1'b1;
      end else begin
        r.vel = -vel;
      end
    end
    return r;
  endfunction

  axis_t mx, my;
  assign mx = move_axis(position_x, velocity_x, field_width);
  assign my = move_axis(position_y, velocity_y, field_height);

  assign sq_start = (state == S_SUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      field_width      <= 12'd1280;
      field_height     <= 12'd540;
      drag_factor      <= 16'd64225;
      position_x       <= '0;
      position_y       <= '0;
      velocity_x       <= '0;
      velocity_y       <= '0;
      attract_x        <= '0;
      attract_y        <= '0;
      period_start_ms  <= '0;
      period_length_ms <= '0;
      m_axis_tvalid    <= 1'b0;
      dv_start         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegFieldWidth:  field_width  <= cfg_data[PixW-1:0];
          RegFieldHeight: field_height <= cfg_data[PixW-1:0];
          RegDragFactor:  drag_factor  <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != S_MOVE) m_axis_tvalid <= 1'b0;

      // The divider starts in the first wait cycle, once its numerator is in place.
      dv_start <= (state == S_FXM || state == S_FYM) && (len != '0);

      case (state)
        S_IDLE: begin
          if (accept) begin
            clip <= 1'b0;
            retg <= ((now - period_start_ms) >= 32'(period_length_ms));
            if ((now - period_start_ms) >= 32'(period_length_ms)) begin
              attract_x        <= s_axis_tdata[43:32];
              attract_y        <= s_axis_tdata[55:44];
              period_length_ms <= s_axis_tdata[71:56];
              period_start_ms  <= now;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          ndx    <= dx_s[DiffW-1];
          ndy    <= dy_s[DiffW-1];
          adx    <= dx_s[DiffW-1] ? MagW'(-dx_s) : MagW'(dx_s);
          ady    <= dy_s[DiffW-1] ? MagW'(-dy_s) : MagW'(dy_s);
          border <= (pxs < BorderLo) || (pxs > hix) || (pys < BorderLo) || (pys > hiy);
          state  <= S_SQX;
        end
        S_SQX: begin
          sumsq <= SqW'(adx) * SqW'(adx);
          state <= S_SQY;
        end
        S_SQY: begin
          prod  <= SqW'(ady) * SqW'(ady);
          state <= S_SUM;
        end
        S_SUM: begin
          // The root unit takes the sum of both squares as it starts.
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            len   <= sq_root;
            state <= S_DRAGX;
          end
        end
        S_DRAGX: begin
          prod  <= SqW'(mag_of(velocity_x)) * SqW'(drag_factor);
          state <= S_DRAGY;
        end
        S_DRAGY: begin
          vdx   <= apply_sign(velocity_x[VelW-1], round_q16(prod));
          prod  <= SqW'(mag_of(velocity_y)) * SqW'(drag_factor);
          state <= S_FXM;
        end
        S_FXM: begin
          vdy   <= apply_sign(velocity_y[VelW-1], round_q16(prod));
          prod  <= SqW'(adx) * SqW'(ForceQ16);
          state <= S_DIVX;
        end
        S_DIVX: begin
          // A zero length means the particle sits on the target: no force.
          if (len == '0) begin
            fx    <= '0;
            state <= S_FYM;
          end else if (dv_done) begin
            fx    <= dv_quot;
            state <= S_FYM;
          end
        end
        S_FYM: begin
          prod  <= SqW'(ady) * SqW'(ForceQ16);
          state <= S_DIVY;
        end
        S_DIVY: begin
          if (len == '0) begin
            fy    <= '0;
            state <= S_SAT;
          end else if (dv_done) begin
            fy    <= dv_quot;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          velocity_x <= sat20(sx);
          velocity_y <= sat20(sy);
          if (sx > (VelW+2)'(VelMax) || sx < (VelW+2)'(VelMin) ||
              sy > (VelW+2)'(VelMax) || sy < (VelW+2)'(VelMin)) begin
            clip <= 1'b1;
          end
          state <= border ? S_DAMPX : S_MOVE;
        end
        S_DAMPX: begin
          prod  <= SqW'(mag_of(velocity_x)) * SqW'(DampQ16);
          state <= S_DAMPY;
        end
        S_DAMPY: begin
          velocity_x <= VelW'(apply_sign(velocity_x[VelW-1], round_q16(prod)));
          prod       <= SqW'(mag_of(velocity_y)) * SqW'(DampQ16);
          state      <= S_DAMPF;
        end
        S_DAMPF: begin
          velocity_y <= VelW'(apply_sign(velocity_y[VelW-1], round_q16(prod)));
          state      <= S_MOVE;
        end
        S_MOVE: begin
          // Wait here while the previous result still sits in the output.
          if (!m_axis_tvalid || m_axis_tready) begin
            position_x    <= mx.pos;
            position_y    <= my.pos;
            velocity_x    <= mx.vel;
            velocity_y    <= my.vel;
            m_axis_tdata  <= {my.pos, mx.pos};
            m_axis_tuser  <= {clip | mx.clip | my.clip, retg};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/pas_sqrt.sv]
module pas_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pas_pkg::SqW-1:0]   value,
  output logic                      done,
  output logic [pas_pkg::RootW-1:0] root
);
  import pas_pkg::*;

  // Two bits of the radicand enter per cycle; one root bit leaves.
  logic              busy;
  logic [4:0]        cnt;
  logic [SqW-1:0]    val;
  logic [23:0]       rem;
  logic [23:0]       rem_sh;
  logic [23:0]       trial;
  logic              take;

  assign rem_sh = {rem[21:0], val[SqW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        val  <= value;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        val <= {val[SqW-3:0], 2'b00};
        if (take) begin
          rem  <= rem_sh - trial;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RootW-2:0], 1'b0};
        end
        if (cnt == 5'(RootW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

endmodule

[rtl/pas_div.sv]
module pas_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pas_pkg::NumW-1:0]  num,
  input  logic [pas_pkg::DenW-1:0]  den,
  output logic                      done,
  output logic [pas_pkg::QuotW-1:0] quot
);
  import pas_pkg::*;

  // Restoring division, one quotient bit per cycle, most significant first.
  logic            busy;
  logic [2:0]      cnt;
  logic [NumW-1:0] rem;
  logic [NumW-1:0] dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num;
        dsh  <= NumW'({den, 7'b0});
        quot <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[QuotW-2:0], 1'b1};
        end else begin
          quot <= {quot[QuotW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (cnt == 3'(QuotW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule
